// ----- rtl/core/ttip_pkg.sv -----
// ============================================================================
// Text-to-integer parser package
// Word types, field widths, character codes and parser phases shared by the
// parser core and its checker.
// ============================================================================
package ttip_pkg;

    // Field widths of the result word and of the base.
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 16;
    localparam int RADIX_BITS = 5;

    // Character codes that steer the parse.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    // Bases chosen by prefix detection.
    localparam logic [RADIX_BITS-1:0] BASE_AUTO = 5'd0;
    localparam logic [RADIX_BITS-1:0] BASE_OCT  = 5'd8;
    localparam logic [RADIX_BITS-1:0] BASE_DEC  = 5'd10;
    localparam logic [RADIX_BITS-1:0] BASE_HEX  = 5'd16;

    // Digit code for a character that is no digit; no base can exceed it.
    localparam logic [RADIX_BITS-1:0] DIGIT_NONE = 5'd31;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SPACE  = 3'd1,
        PH_SIGNED = 3'd2,
        PH_ZERO   = 3'd3,
        PH_DIGITS = 3'd4
    } phase_t;

    // One input word: a character and the start-of-string flag.
    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } char_word_t;

    // One result word: the signed value and the consumed character count.
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic        [COUNT_BITS-1:0] consumed;
    } result_word_t;

    // Digit value of a character, or DIGIT_NONE.
    function automatic logic [RADIX_BITS-1:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c inside {[8'h30:8'h39]})
            begin
                d = c - 8'h30;
            end
            else if (c inside {[8'h61:8'h66]})
            begin
                d = c - 8'h57;
            end
            else if (c inside {[8'h41:8'h46]})
            begin
                d = c - 8'h37;
            end
            else
            begin
                d = {3'b000, DIGIT_NONE};
            end
            return d[RADIX_BITS-1:0];
        end
    endfunction

endpackage

// ----- rtl/core/text_to_integer_parser_core.sv -----
// ============================================================================
// Text-to-integer parser core
// Streaming strtol-style parser: one character per word, at most one result per string.
// ============================================================================
// The core takes one character word per clock unless the input stalls, and gives
// at most one result word per string. The character that ends the number is
// captured in the input register, where the digit multiply-add works on it, and
// the result register loads from it once it has room. The multiply-add of the
// accumulator by the base sets the clock period. The base register is sampled
// when a word with first set is processed, so the user must write it only while
// the core is idle; the core itself does not enforce this. A result word holds in
// its register while stalled; characters that give no result keep flowing past it,
// and the input stalls only for a result that has no room.
module text_to_integer_parser_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                char_valid,
    output logic                                char_stall,
    input  ttip_pkg::char_word_t                char_word,
    output logic                                result_valid,
    input  logic                                result_stall,
    output ttip_pkg::result_word_t              result_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ttip_pkg::RADIX_BITS-1:0]     cfg_data
);
    import ttip_pkg::*;

    // Configuration and input register.
    logic [RADIX_BITS-1:0] radix_reg;
    logic                  in_full_reg;
    char_word_t            in_word_reg;

    // Parser state.
    phase_t                phase_reg, phase_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  neg_reg, neg_next;
    logic [RADIX_BITS-1:0] base_reg, base_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;

    // Result register.
    logic                  out_valid_reg;
    result_word_t          out_word_reg;

    // Combinational step results.
    logic                  emit;
    logic                  proceed;
    logic                  accept;
    logic                  out_free;
    logic                  stop;
    logic                  bump;
    logic [RADIX_BITS-1:0] digit;
    logic [VALUE_BITS-1:0] acc_start;

    // The base register is always ready for a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= BASE_DEC;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radix_reg <= cfg_data;
        end
    end

    // Handshake: a word in the input register moves on unless it ends a
    // number and the result register cannot take the result.
    assign out_free   = !out_valid_reg || !result_stall;
    assign proceed    = in_full_reg && (!emit || out_free);
    assign char_stall = in_full_reg && !proceed;
    assign accept     = char_valid && !char_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= accept || char_stall;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg <= char_word;
        end
    end

    // Parser state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            base_reg  <= BASE_AUTO;
            cnt_reg   <= '0;
        end
        else if (proceed)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            base_reg  <= base_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Accumulator value this character starts from.
    assign acc_start = in_word_reg.first ? '0 : acc_reg;

    // Next state: walk the phases that this character passes through.
    always_comb
    begin
        phase_next = in_word_reg.first ? PH_SPACE : phase_reg;
        acc_next   = acc_start;
        neg_next   = in_word_reg.first ? 1'b0 : neg_reg;
        base_next  = in_word_reg.first ? radix_reg : base_reg;
        cnt_next   = in_word_reg.first ? '0 : cnt_reg;
        digit      = digit_of(in_word_reg.ch);
        stop       = 1'b0;
        bump       = 1'b0;
        emit       = 1'b0;

        case (phase_next)
            PH_IDLE:
            begin
                stop = 1'b1;
            end
            default:
            begin
            end
        endcase

        // Leading whitespace and an optional sign.
        if (!stop && phase_next == PH_SPACE)
        begin
            if (in_word_reg.ch == CH_SPACE || in_word_reg.ch == CH_TAB)
            begin
                bump = 1'b1;
                stop = 1'b1;
            end
            else
            begin
                phase_next = PH_SIGNED;
                if (in_word_reg.ch == CH_MINUS || in_word_reg.ch == CH_PLUS)
                begin
                    neg_next = (in_word_reg.ch == CH_MINUS);
                    bump     = 1'b1;
                    stop     = 1'b1;
                end
            end
        end

        // Base detection from a leading zero.
        if (!stop && phase_next == PH_SIGNED)
        begin
            if (base_next == BASE_AUTO)
            begin
                if (in_word_reg.ch == CH_ZERO)
                begin
                    bump       = 1'b1;
                    phase_next = PH_ZERO;
                    stop       = 1'b1;
                end
                else
                begin
                    base_next = BASE_DEC;
                end
            end
            if (!stop)
            begin
                phase_next = PH_DIGITS;
            end
        end

        // Hex prefix after the leading zero, else octal.
        if (!stop && phase_next == PH_ZERO)
        begin
            if (in_word_reg.ch == CH_LOW_X || in_word_reg.ch == CH_UP_X)
            begin
                bump       = 1'b1;
                base_next  = BASE_HEX;
                phase_next = PH_DIGITS;
                stop       = 1'b1;
            end
            else
            begin
                base_next  = BASE_OCT;
                phase_next = PH_DIGITS;
            end
        end

        // Digits accumulate through the multiply-add; anything else ends
        // the number.
        if (!stop && phase_next == PH_DIGITS)
        begin
            if (digit < base_next)
            begin
                acc_next = acc_start * {{(VALUE_BITS-RADIX_BITS){1'b0}}, base_next}
                         + {{(VALUE_BITS-RADIX_BITS){1'b0}}, digit};
                bump     = 1'b1;
            end
            else
            begin
                emit       = 1'b1;
                phase_next = PH_IDLE;
            end
        end

        // Saturating character count.
        if (bump && cnt_next != '1)
        begin
            cnt_next = cnt_next + 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proceed && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proceed && emit)
        begin
            out_word_reg.value    <= neg_next ? -acc_next : acc_next;
            out_word_reg.consumed <= cnt_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

endmodule

// ----- rtl/core/ttip_checker.sv -----
// ============================================================================
// Text-to-integer parser checker
// Port-level checks on the parser core's handshakes over time.
// ============================================================================
module ttip_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    char_stall,
    input logic                    result_valid,
    input logic                    result_stall,
    input ttip_pkg::result_word_t  result_word
);
    import ttip_pkg::*;

    // Reset empties both the input register and the result register.
    assert property (@(posedge clk) !rst_n |-> (!result_valid && !char_stall))
        else $error("ttip: result or stall active during reset");

    // The input only stalls behind a result word that is itself stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> (result_valid && result_stall))
        else $error("ttip: input stalled while the result side is free");

    // A stalled result word holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result_word)))
        else $error("ttip: stalled result word changed or dropped");

endmodule

bind text_to_integer_parser_core ttip_checker u_ttip_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .char_stall   (char_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
);

// ----- dv/tb_text_to_integer_parser_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Text-to-integer parser core testbench
// Streams strings one character word at a time into the parser and checks
// every result word against a cycle-free parse kept inside the bench. A short
// directed part covers prefixes, signs, odd bases and restarts; random
// strings follow under changing bases and random idling on both sides.
// ============================================================================
module tb_text_to_integer_parser_core;

    import ttip_pkg::*;

    localparam real CLK_PERIOD     = 12.0;
    localparam int  RESET_CYCLES   = 12;
    localparam int  RANDOM_ITEMS   = 1650;
    localparam int  SEGMENT_ITEMS  = 110;
    localparam int  SETTLE_CYCLES  = 6;
    localparam int  HOLD_CYCLES    = 400;
    localparam int  HOLD_AFTER     = 30;
    localparam int  WATCHDOG_LIMIT = 5000;

    // Bases that sit at the ends of the register range.
    localparam logic [RADIX_BITS-1:0] RADIX_ONE = 5'd1;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX = 5'd31;

    // Character codes used by the stimulus beyond those in the package.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] NO_DIGIT = 8'hFF;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         char_valid   = 1'b0;
    logic         char_stall;
    char_word_t   char_word    = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_word_t result_word;
    logic         cfg_valid    = 1'b0;
    logic         cfg_ready;
    logic [RADIX_BITS-1:0] cfg_data = '0;

    // Words waiting to be sent and numbers the parser still owes.
    char_word_t   char_backlog[$];
    result_word_t parsed_numbers[$];

    int  sender_idle_pct   = 30;
    int  receiver_idle_pct = 86;
    int  errors            = 0;
    int  results_seen      = 0;
    int  random_items      = 0;
    int  hold_left         = 0;
    bit  hold_done         = 1'b0;
    bit  char_taken        = 1'b0;
    int  quiet_cycles      = 0;

    // Shadow copy of the base register and of the parse state.
    logic [RADIX_BITS-1:0] radix_shadow = BASE_DEC;
    phase_t                pr_phase     = PH_IDLE;
    logic [VALUE_BITS-1:0] pr_acc       = '0;
    logic                  pr_neg       = 1'b0;
    logic [RADIX_BITS-1:0] pr_base      = '0;
    logic [COUNT_BITS-1:0] pr_count     = '0;

    text_to_integer_parser_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_word    (char_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #(CLK_PERIOD / 2.0) clk = ~clk;
    end

    // Digit value of a character, or NO_DIGIT for anything else.
    function automatic logic [7:0] char_digit(input logic [7:0] c);
        begin
            if (c >= "0" && c <= "9")
            begin
                return c - "0";
            end
            if (c >= "a" && c <= "f")
            begin
                return c - "a" + 8'd10;
            end
            if (c >= "A" && c <= "F")
            begin
                return c - "A" + 8'd10;
            end
            return NO_DIGIT;
        end
    endfunction

    // The character count stops at all ones.
    function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] n);
        begin
            return (n == '1) ? n : n + 1'b1;
        end
    endfunction

    // Advances the parse by one accepted word and records any finished number.
    task automatic parse_char(input char_word_t w);
        logic [7:0]   c;
        logic [7:0]   d;
        result_word_t num;
        begin
            c = w.ch;
            if (w.first)
            begin
                pr_phase = PH_SPACE;
                pr_acc   = '0;
                pr_neg   = 1'b0;
                pr_base  = radix_shadow;
                pr_count = '0;
            end
            if (pr_phase == PH_IDLE)
            begin
                return;
            end
            // Leading blanks, then one optional sign.
            if (pr_phase == PH_SPACE)
            begin
                if (c == CH_SPACE || c == CH_TAB)
                begin
                    pr_count = count_up(pr_count);
                    return;
                end
                pr_phase = PH_SIGNED;
                if (c == CH_MINUS || c == CH_PLUS)
                begin
                    pr_neg   = (c == CH_MINUS);
                    pr_count = count_up(pr_count);
                    return;
                end
            end
            // With base detection, a leading zero may open a prefix.
            if (pr_phase == PH_SIGNED)
            begin
                if (pr_base == BASE_AUTO)
                begin
                    if (c == CH_ZERO)
                    begin
                        pr_count = count_up(pr_count);
                        pr_phase = PH_ZERO;
                        return;
                    end
                    pr_base = BASE_DEC;
                end
                pr_phase = PH_DIGITS;
            end
            if (pr_phase == PH_ZERO)
            begin
                if (c == CH_LOW_X || c == CH_UP_X)
                begin
                    pr_count = count_up(pr_count);
                    pr_base  = BASE_HEX;
                    pr_phase = PH_DIGITS;
                    return;
                end
                pr_base  = BASE_OCT;
                pr_phase = PH_DIGITS;
            end
            // Digits accumulate; the first non-digit closes the number.
            if (pr_phase == PH_DIGITS)
            begin
                d = char_digit(c);
                if (d < {3'b000, pr_base})
                begin
                    pr_acc   = pr_acc * {{(VALUE_BITS-RADIX_BITS){1'b0}}, pr_base}
                             + {{(VALUE_BITS-8){1'b0}}, d};
                    pr_count = count_up(pr_count);
                    return;
                end
                num.value    = pr_neg ? ({VALUE_BITS{1'b0}} - pr_acc) : pr_acc;
                num.consumed = pr_count;
                parsed_numbers.push_back(num);
                pr_phase = PH_IDLE;
            end
        end
    endtask

    task automatic push_char(input logic [7:0] c, input logic f, input bit counted);
        char_word_t w;
        begin
            w.ch    = c;
            w.first = f;
            char_backlog.push_back(w);
            if (counted)
            begin
                random_items++;
            end
        end
    endtask

    // Waits until every word is sent and every number has come back.
    task automatic drain();
        begin
            while (char_backlog.size() != 0 || char_valid || parsed_numbers.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_radix(input logic [RADIX_BITS-1:0] r);
        begin
            @(negedge clk);
            cfg_valid = 1'b1;
            cfg_data  = r;
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            radix_shadow = r;
            @(negedge clk);
            cfg_valid = 1'b0;
        end
    endtask

    // One random string: mostly well formed, sometimes cut short or plain noise.
    task automatic add_random_string();
        int         kind;
        int         n;
        int         i;
        int         gen_base;
        int         d;
        logic       lead;
        logic [7:0] c;
        begin
            kind = $urandom_range(99);
            lead = 1'b1;
            if (kind < 10)
            begin
                n = $urandom_range(1, 5);
                for (i = 0; i < n; i++)
                begin
                    push_char(8'($urandom_range(255)), lead | ($urandom_range(7) == 0), 1'b1);
                    lead = 1'b0;
                end
                return;
            end
            // Blanks and sign.
            if ($urandom_range(1) == 0)
            begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                begin
                    push_char($urandom_range(1) ? CH_SPACE : CH_TAB, lead, 1'b1);
                    lead = 1'b0;
                end
            end
            case ($urandom_range(3))
                0:
                begin
                    push_char(CH_MINUS, lead, 1'b1);
                    lead = 1'b0;
                end
                1:
                begin
                    push_char(CH_PLUS, lead, 1'b1);
                    lead = 1'b0;
                end
                default: ;
            endcase
            // Prefix under base detection.
            if (radix_shadow == BASE_AUTO)
            begin
                case ($urandom_range(3))
                    0, 1:
                    begin
                        push_char(CH_ZERO, lead, 1'b1);
                        push_char($urandom_range(1) ? CH_LOW_X : CH_UP_X, 1'b0, 1'b1);
                        lead     = 1'b0;
                        gen_base = 16;
                    end
                    2:
                    begin
                        push_char(CH_ZERO, lead, 1'b1);
                        lead     = 1'b0;
                        gen_base = 8;
                    end
                    default: gen_base = 10;
                endcase
            end
            else
            begin
                gen_base = (radix_shadow > BASE_HEX) ? 16 : int'(radix_shadow);
            end
            // Digits, now and then a long run that wraps the value.
            n = ($urandom_range(3) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 8);
            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(19) == 0)
                begin
                    d = $urandom_range(15);
                end
                else
                begin
                    d = $urandom_range(gen_base - 1);
                end
                if (d < 10)
                begin
                    c = CH_ZERO + 8'(d);
                end
                else
                begin
                    c = ($urandom_range(1) ? CH_LOW_A : CH_UP_A) + 8'(d - 10);
                end
                push_char(c, lead, 1'b1);
                lead = 1'b0;
            end
            // A string cut short here is dropped by the next start.
            if ($urandom_range(11) == 0)
            begin
                return;
            end
            push_char($urandom_range(1) ? CH_NUL : 8'($urandom_range(255)), lead, 1'b1);
            n = $urandom_range(0, 2);
            for (i = 0; i < n; i++)
            begin
                push_char(8'($urandom_range(255)), 1'b0, 1'b1);
            end
        end
    endtask

    // Sender: offers the next word at the falling edge once the last one is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!char_valid || char_taken))
        begin
            if (char_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                char_valid <= 1'b1;
                char_word  <= char_backlog.pop_front();
            end
            else
            begin
                char_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the core up.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left    = hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_done    = 1'b1;
            hold_left    = HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    // Monitor: feeds accepted words to the parse and checks each result word.
    always @(posedge clk)
    begin
        char_taken = rst_n && char_valid && !char_stall;
        if (char_taken)
        begin
            parse_char(char_word);
        end
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (parsed_numbers.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, value %0d consumed %0d",
                         $time, result_word.value, result_word.consumed);
            end
            else
            begin
                if (result_word.value !== parsed_numbers[0].value)
                begin
                    errors++;
                    $display("%0t: value mismatch, expected %0d, actual %0d",
                             $time, parsed_numbers[0].value, result_word.value);
                end
                if (result_word.consumed !== parsed_numbers[0].consumed)
                begin
                    errors++;
                    $display("%0t: consumed mismatch, expected %0d, actual %0d",
                             $time, parsed_numbers[0].consumed, result_word.consumed);
                end
                void'(parsed_numbers.pop_front());
            end
        end
    end

    // Watchdog: ends the run when no word moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((char_valid && !char_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready) || !rst_n)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles, %0d numbers outstanding",
                         $time, quiet_cycles, parsed_numbers.size());
                $display("** text_to_integer_parser_core: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        int seg_start;
        logic [RADIX_BITS-1:0] r;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset base of ten.
        push_char(8'hFF, 1'b0, 1'b0);          // idle character, ignored
        push_char(CH_TAB, 1'b1, 1'b0);
        push_char(CH_MINUS, 1'b0, 1'b0);
        push_char("9", 1'b0, 1'b0);
        push_char("z", 1'b0, 1'b0);
        push_char("1", 1'b1, 1'b0);            // dropped by the restart below
        push_char(CH_NUL, 1'b1, 1'b0);
        drain();

        // Base detection: hex prefix with no digits, then an octal number.
        write_radix(BASE_AUTO);
        push_char(CH_ZERO, 1'b1, 1'b0);
        push_char(CH_LOW_X, 1'b0, 1'b0);
        push_char("g", 1'b0, 1'b0);
        push_char(CH_ZERO, 1'b1, 1'b0);
        push_char("7", 1'b0, 1'b0);
        push_char(CH_NUL, 1'b0, 1'b0);
        drain();

        // Base above sixteen takes hex digits but multiplies by the register.
        write_radix(RADIX_MAX);
        push_char("F", 1'b1, 1'b0);
        push_char("f", 1'b0, 1'b0);
        push_char(CH_NUL, 1'b0, 1'b0);
        drain();

        // Base one accepts only zeros.
        write_radix(RADIX_ONE);
        push_char(CH_ZERO, 1'b1, 1'b0);
        push_char(CH_ZERO, 1'b0, 1'b0);
        push_char("2", 1'b0, 1'b0);
        // A register write inside a string waits for the next string.
        push_char(CH_PLUS, 1'b1, 1'b0);
        drain();
        write_radix(BASE_HEX);
        push_char("7", 1'b0, 1'b0);
        push_char(CH_NUL, 1'b0, 1'b0);
        // Most negative value.
        push_char(CH_MINUS, 1'b1, 1'b0);
        push_char("8", 1'b0, 1'b0);
        for (i = 0; i < 7; i++)
        begin
            push_char(CH_ZERO, 1'b0, 1'b0);
        end
        push_char(CH_NUL, 1'b0, 1'b0);
        drain();

        // Random strings in segments, each under its own base.
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items >= (2 * RANDOM_ITEMS) / 3)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            else if (random_items >= RANDOM_ITEMS / 3)
            begin
                sender_idle_pct   = 86;
                receiver_idle_pct = 30;
            end
            case ($urandom_range(7))
                0, 1: r = BASE_AUTO;
                2:    r = BASE_DEC;
                3:    r = BASE_HEX;
                4:    r = BASE_OCT;
                5:    r = RADIX_ONE;
                6:    r = RADIX_MAX;
                default: r = RADIX_BITS'($urandom_range(31));
            endcase
            write_radix(r);
            seg_start = random_items;
            while (random_items - seg_start < SEGMENT_ITEMS)
            begin
                add_random_string();
            end
            drain();
        end

        if (errors == 0)
        begin
            $display("** text_to_integer_parser_core: PASSED **");
        end
        else
        begin
            $display("** text_to_integer_parser_core: FAILED **");
        end
        $finish;
    end

endmodule
